/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the power derate limiter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pdl_pkg.sv */
// Types and constants shared by the power derate limiter modules
`timescale 1ns / 1ps

package pdl_pkg;

  // Port widths
  localparam int IN_W       = 64;
  localparam int OUT_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Field widths
  localparam int LIM_W   = 17;
  localparam int TGT_W   = 17;
  localparam int TEMP_W  = 12;
  localparam int PV_W    = 14;
  localparam int PWR_W   = 17;
  localparam int POW_W   = 16;
  localparam int TICK_W  = 10;
  localparam int RTICK_W = 12;
  localparam int ACC_W   = 22;

  // Full-scale current limit in Q16
  localparam logic [LIM_W-1:0] Q16_ONE = 17'd65536;

  // Derate slopes in 0.1 W per 0.1 C and per 0.1 V
  localparam logic signed [19:0] THERM_SLOPE = 20'sd40;
  localparam logic signed [19:0] PV_SLOPE    = 20'sd8;

  // Saturation bounds of the target power
  localparam logic signed [19:0] TGT_MIN = -20'sd65536;
  localparam logic signed [19:0] TGT_MAX = 20'sd65535;

  // Integrator step: floor((diff * 2^21 + 1875000) / 3750000).
  // Dropping a factor of 16 gives floor((diff * 2^17 + 117187) / 234375).
  // Adding 2^17 * 234375 to the numerator makes it non-negative:
  // u = diff + 234375, step = floor((u * 2^17 + 117187) / 234375) - 2^17.
  // The quotient is (u * 2^17 + 117187) * R / 2^54 with R = ceil(2^54 / 234375), exact for
  // numerators below 2^36.
  localparam longint unsigned DIV_D   = 64'd234375;
  localparam longint unsigned DIV_C   = 64'd117187;
  localparam longint unsigned DIV_R   = ((64'd1 << 54) + DIV_D - 64'd1) / DIV_D;
  localparam longint unsigned DIV_CRH = (DIV_C * DIV_R) >> 17;
  localparam logic [18:0] DIV_RL  = DIV_R[18:0];
  localparam logic [17:0] DIV_RH  = DIV_R[36:19];
  localparam logic [18:0] Q_BIAS  = 19'd131072;

  // Register reset values
  localparam logic [16:0]        RST_MAX_CL     = 17'd65536;
  localparam logic [15:0]        RST_OVL_PWR    = 16'd33000;
  localparam logic [15:0]        RST_RATED_PWR  = 16'd30000;
  localparam logic signed [11:0] RST_TEMP_START = 12'sd650;
  localparam logic [13:0]        RST_PV_START   = 14'd5000;
  localparam logic [9:0]         RST_TEMP_DELAY = 10'd500;
  localparam logic [9:0]         RST_OVL_TICKS  = 10'd300;
  localparam logic [11:0]        RST_REC_TICKS  = 12'd3000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_CL     = 3'd0,
    CFG_OVL_PWR    = 3'd1,
    CFG_RATED_PWR  = 3'd2,
    CFG_TEMP_START = 3'd3,
    CFG_PV_START   = 3'd4,
    CFG_TEMP_DELAY = 3'd5,
    CFG_OVL_TICKS  = 3'd6,
    CFG_REC_TICKS  = 3'd7
  } pdl_cfg_idx_t;

  // Configuration register file
  typedef struct packed {
    logic [16:0]        max_cl;
    logic [15:0]        ovl_pwr;
    logic [15:0]        rated_pwr;
    logic signed [11:0] temp_start;
    logic [13:0]        pv_start;
    logic [9:0]         temp_delay;
    logic [9:0]         ovl_ticks;
    logic [11:0]        rec_ticks;
  } pdl_cfg_t;

  // Pipeline control from the top level
  typedef struct packed {
    logic adv;
    logic s1_vld;
    logic s3_vld;
  } pdl_stage_t;

  // Per-item status flags
  typedef struct packed {
    logic grid;
    logic ovl;
    logic therm;
  } pdl_flags_t;

endpackage

/* rtl/pdl_cap_ctrl.sv */
// Power cap stage: derate timers, overload hysteresis and target power minimum
`timescale 1ns / 1ps

module pdl_cap_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pdl_pkg::pdl_stage_t           stg,
  input  pdl_pkg::pdl_cfg_t             cfg,
  input  logic                          grid,
  input  logic signed [pdl_pkg::TEMP_W-1:0] temp,
  input  logic [pdl_pkg::PV_W-1:0]      pv1,
  input  logic [pdl_pkg::PV_W-1:0]      pv2,
  input  logic signed [pdl_pkg::PWR_W-1:0]  pwr,
  output logic signed [pdl_pkg::TGT_W-1:0]  tgt_r,
  output logic signed [pdl_pkg::PWR_W-1:0]  pwr_r,
  output pdl_pkg::pdl_flags_t           flags_r
);
  import pdl_pkg::*;

  logic [TICK_W-1:0]  hot_cnt_r, hot_cnt_nxt, hot_inc;
  logic [TICK_W-1:0]  ovr_cnt_r, ovr_cnt_nxt, ovr_inc;
  logic [RTICK_W-1:0] rec_cnt_r, rec_cnt_nxt, rec_inc;
  logic               act_r, act_nxt;

  logic               hot, therm, over;
  logic               pv1_hi, pv2_hi;
  logic signed [12:0] dt;
  logic signed [14:0] pd1, pd2;
  logic signed [19:0] ovl20, rated20, cand_t, cand_p1, cand_p2, tmin, tsat;
  logic signed [TGT_W-1:0] tgt_nxt;
  pdl_flags_t         flags_nxt;

  // Thermal derate: count hot ticks, saturating at the delay
  always_comb begin
    hot     = temp > cfg.temp_start;
    hot_inc = (hot_cnt_r < cfg.temp_delay) ? hot_cnt_r + 10'd1 : hot_cnt_r;
    therm   = hot && (hot_inc >= cfg.temp_delay);
    dt      = {temp[TEMP_W-1], temp} - {cfg.temp_start[11], cfg.temp_start};
  end

  // PV over-voltage derate for each string
  always_comb begin
    pv1_hi = pv1 > cfg.pv_start;
    pv2_hi = pv2 > cfg.pv_start;
    pd1    = $signed({1'b0, pv1}) - $signed({1'b0, cfg.pv_start});
    pd2    = $signed({1'b0, pv2}) - $signed({1'b0, cfg.pv_start});
  end

  // Candidate caps
  always_comb begin
    ovl20   = $signed({4'd0, cfg.ovl_pwr});
    rated20 = $signed({4'd0, cfg.rated_pwr});
    cand_t  = ovl20 - 20'(dt) * THERM_SLOPE;
    cand_p1 = ovl20 - 20'(pd1) * PV_SLOPE;
    cand_p2 = ovl20 - 20'(pd2) * PV_SLOPE;
  end

  // Overload hysteresis: step down after a run above rated, return after a run below
  always_comb begin
    over        = $signed({pwr[PWR_W-1], pwr}) > $signed({2'b00, cfg.rated_pwr});
    ovr_inc     = (ovr_cnt_r < cfg.ovl_ticks) ? ovr_cnt_r + 10'd1 : ovr_cnt_r;
    rec_inc     = (rec_cnt_r < cfg.rec_ticks) ? rec_cnt_r + 12'd1 : rec_cnt_r;
    ovr_cnt_nxt = ovr_cnt_r;
    rec_cnt_nxt = rec_cnt_r;
    act_nxt     = act_r;
    if (over) begin
      rec_cnt_nxt = '0;
      if (!act_r) begin
        ovr_cnt_nxt = ovr_inc;
        act_nxt     = ovr_inc >= cfg.ovl_ticks;
      end
    end else begin
      ovr_cnt_nxt = '0;
      if (act_r) begin
        rec_cnt_nxt = rec_inc;
        act_nxt     = !(rec_inc >= cfg.rec_ticks);
      end
    end
    hot_cnt_nxt = hot ? hot_inc : '0;
  end

  // Minimum of the caps, saturated to the target range, and zero while off grid
  always_comb begin
    tmin = ovl20;
    if (therm && (cand_t < tmin)) tmin = cand_t;
    if (pv1_hi && (cand_p1 < tmin)) tmin = cand_p1;
    if (pv2_hi && (cand_p2 < tmin)) tmin = cand_p2;
    if (act_nxt && (rated20 < tmin)) tmin = rated20;
    if (tmin < TGT_MIN) begin
      tsat = TGT_MIN;
    end else if (tmin > TGT_MAX) begin
      tsat = TGT_MAX;
    end else begin
      tsat = tmin;
    end
    tgt_nxt         = grid ? tsat[TGT_W-1:0] : '0;
    flags_nxt.grid  = grid;
    flags_nxt.ovl   = grid & act_nxt;
    flags_nxt.therm = grid & therm;
  end

  // Advance state once per item; drop it all while off grid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_cnt_r <= '0;
      ovr_cnt_r <= '0;
      rec_cnt_r <= '0;
      act_r     <= 1'b0;
    end else if (stg.adv && stg.s1_vld) begin
      if (grid) begin
        hot_cnt_r <= hot_cnt_nxt;
        ovr_cnt_r <= ovr_cnt_nxt;
        rec_cnt_r <= rec_cnt_nxt;
        act_r     <= act_nxt;
      end else begin
        hot_cnt_r <= '0;
        ovr_cnt_r <= '0;
        rec_cnt_r <= '0;
        act_r     <= 1'b0;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (stg.adv) begin
      tgt_r   <= tgt_nxt;
      pwr_r   <= pwr;
      flags_r <= flags_nxt;
    end
  end

endmodule

/* rtl/pdl_integrator.sv */
// Integrator: power error to Q21 step by reciprocal multiply, clamped accumulator
`timescale 1ns / 1ps

module pdl_integrator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pdl_pkg::pdl_stage_t               stg,
  input  pdl_pkg::pdl_cfg_t                 cfg,
  input  logic signed [pdl_pkg::TGT_W-1:0]  tgt,
  input  logic signed [pdl_pkg::PWR_W-1:0]  pwr,
  input  pdl_pkg::pdl_flags_t               flags,
  output logic [pdl_pkg::LIM_W-1:0]         lim_r,
  output logic signed [pdl_pkg::TGT_W-1:0]  tgt_o_r,
  output pdl_pkg::pdl_flags_t               flags_o_r
);
  import pdl_pkg::*;

  logic signed [17:0] diff;
  logic [19:0]        u_ext;
  logic [18:0]        u;
  logic [36:0]        ph_r;
  logic [37:0]        pl_r;
  logic signed [TGT_W-1:0] tgt3_r;
  pdl_flags_t         flags3_r;

  logic [55:0]        wsum;
  logic [18:0]        q_p;
  logic signed [18:0] q;
  logic signed [23:0] sum;
  logic [LIM_W-1:0]   ceil_lim;
  logic [ACC_W-1:0]   cap;
  logic [ACC_W-1:0]   acc_r, acc_nxt;

  // Offset error so the dividend is non-negative
  always_comb begin
    diff  = {tgt[TGT_W-1], tgt} - {pwr[PWR_W-1], pwr};
    u_ext = {{2{diff[17]}}, diff} + 20'(DIV_D);
    u     = u_ext[18:0];
  end

  // Partial products of u times the reciprocal
  always_ff @(posedge clk) begin
    if (stg.adv) begin
      ph_r     <= 37'(u) * 37'(DIV_RH);
      pl_r     <= 38'(u) * 38'(DIV_RL);
      tgt3_r   <= tgt;
      flags3_r <= flags;
    end
  end

  // Combine partials, take the quotient, remove the offset
  always_comb begin
    wsum = {ph_r, 19'd0} + 56'(pl_r) + 56'(DIV_CRH);
    q_p  = wsum[55:37];
    q    = $signed(q_p - Q_BIAS);
  end

  // Accumulate and clamp to [0, ceiling * 32]; clear while off grid
  always_comb begin
    ceil_lim = (cfg.max_cl > Q16_ONE) ? Q16_ONE : cfg.max_cl;
    cap      = {ceil_lim, 5'd0};
    sum      = $signed({2'b00, acc_r}) + {{5{q[18]}}, q};
    if (sum > $signed({2'b00, cap})) begin
      acc_nxt = cap;
    end else if (sum < 24'sd0) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = sum[ACC_W-1:0];
    end
    if (!flags3_r.grid) acc_nxt = '0;
  end

  // Hold the accumulator between items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (stg.adv && stg.s3_vld) begin
      acc_r <= acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (stg.adv) begin
      lim_r     <= acc_nxt[ACC_W-1:5];
      tgt_o_r   <= tgt3_r;
      flags_o_r <= flags3_r;
    end
  end

endmodule

/* rtl/inverter_power_derate_limiter_top.sv */
// Top level of the inverter power derate limiter: ports, config registers, pipeline control
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one control tick per transfer and returns one result per tick, in order.
// Throughput is one item per clock while out_tready does not stall; an item passes
// the input register, cap stage, multiplier stage and accumulator stage. The
// stages advance together, so a stall on out_tready holds the whole pipeline and
// in_tready drops with it. The timers, the overload flag and the current-limit
// accumulator change only as an item passes, so results depend on item order
// alone. Configuration writes are taken in any cycle and should land while no
// item is in flight. There is no clearing pass after reset.
module inverter_power_derate_limiter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: grid_connected[0], temperature[12:1], pv1_voltage[26:13],
  //           pv2_voltage[40:27], active_power[57:41], zero[63:58]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pdl_pkg::IN_W-1:0]          in_tdata,
  // out_tdata: current_limit[16:0], target_power[33:17], overload_stepped[34],
  //            thermal_derating[35], zero[39:36]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pdl_pkg::OUT_W-1:0]         out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pdl_pkg::*;

  pdl_cfg_t    cfg_r;
  pdl_stage_t  stg;
  logic        adv;
  logic        v1_r, v2_r, v3_r, ov_r;

  logic                     grid1_r;
  logic signed [TEMP_W-1:0] temp1_r;
  logic [PV_W-1:0]          pv1_1_r, pv2_1_r;
  logic signed [PWR_W-1:0]  pwr1_r;

  logic signed [TGT_W-1:0]  tgt2;
  logic signed [PWR_W-1:0]  pwr2;
  pdl_flags_t               flags2;
  logic [LIM_W-1:0]         lim_o;
  logic signed [TGT_W-1:0]  tgt_o;
  pdl_flags_t               flags_o;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_cl     <= RST_MAX_CL;
      cfg_r.ovl_pwr    <= RST_OVL_PWR;
      cfg_r.rated_pwr  <= RST_RATED_PWR;
      cfg_r.temp_start <= RST_TEMP_START;
      cfg_r.pv_start   <= RST_PV_START;
      cfg_r.temp_delay <= RST_TEMP_DELAY;
      cfg_r.ovl_ticks  <= RST_OVL_TICKS;
      cfg_r.rec_ticks  <= RST_REC_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (pdl_cfg_idx_t'(cfg_index))
        CFG_MAX_CL:     cfg_r.max_cl     <= cfg_data[16:0];
        CFG_OVL_PWR:    cfg_r.ovl_pwr    <= cfg_data[15:0];
        CFG_RATED_PWR:  cfg_r.rated_pwr  <= cfg_data[15:0];
        CFG_TEMP_START: cfg_r.temp_start <= $signed(cfg_data[11:0]);
        CFG_PV_START:   cfg_r.pv_start   <= cfg_data[13:0];
        CFG_TEMP_DELAY: cfg_r.temp_delay <= cfg_data[9:0];
        CFG_OVL_TICKS:  cfg_r.ovl_ticks  <= cfg_data[9:0];
        CFG_REC_TICKS:  cfg_r.rec_ticks  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the result register is free or being taken
  assign adv       = !ov_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ov_r <= v3_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (adv) begin
      grid1_r <= in_tdata[0];
      temp1_r <= $signed(in_tdata[12:1]);
      pv1_1_r <= in_tdata[26:13];
      pv2_1_r <= in_tdata[40:27];
      pwr1_r  <= $signed(in_tdata[57:41]);
    end
  end

  always_comb begin
    stg.adv    = adv;
    stg.s1_vld = v1_r;
    stg.s3_vld = v3_r;
  end

  pdl_cap_ctrl u_cap_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .stg     (stg),
    .cfg     (cfg_r),
    .grid    (grid1_r),
    .temp    (temp1_r),
    .pv1     (pv1_1_r),
    .pv2     (pv2_1_r),
    .pwr     (pwr1_r),
    .tgt_r   (tgt2),
    .pwr_r   (pwr2),
    .flags_r (flags2)
  );

  pdl_integrator u_integrator (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg       (stg),
    .cfg       (cfg_r),
    .tgt       (tgt2),
    .pwr       (pwr2),
    .flags     (flags2),
    .lim_r     (lim_o),
    .tgt_o_r   (tgt_o),
    .flags_o_r (flags_o)
  );

  // Result channel
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, flags_o.therm, flags_o.ovl, tgt_o, lim_o};

  // Helpers for the checks below
  logic signed [17:0] a_tgt, a_rated, a_ovl;
  logic               a_step, a_hot;
  assign a_tgt   = {out_tdata[33], out_tdata[33:17]};
  assign a_rated = $signed({2'b00, cfg_r.rated_pwr});
  assign a_ovl   = $signed({2'b00, cfg_r.ovl_pwr});
  assign a_step  = out_tvalid && out_tdata[34];
  assign a_hot   = out_tvalid && out_tdata[35];

  `ASSERT_NEXT(a_stage_moves, v1_r && adv, v2_r, "cap stage item lost on advance")
  `ASSERT_IMPLY(a_lim_range, out_tvalid, out_tdata[16:0] <= Q16_ONE, "limit above full scale")
  `ASSERT_IMPLY(a_ovl_cap, a_step, a_tgt <= a_rated, "overload set but target above rated")
  `ASSERT_IMPLY(a_therm_cap, a_hot, a_tgt <= a_ovl, "thermal derate above overload cap")

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the inverter power derate limiter top level

module tb;
  import pdl_pkg::*;

  localparam int     CLK_HALF    = 5;
  localparam int     RST_CYCLES  = 9;
  localparam int     DRAIN_CYC   = 8;     // settle margin past the four-stage pipeline
  localparam int     HOLD_LEN    = 60;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     SEG_TICKS   = 84;
  localparam longint Q21_ONE     = 2097152;
  localparam longint STEP_DIV    = 3750000;
  localparam longint STEP_HALF   = 1875000;
  localparam longint ACC_SCALE   = 32;

  // One control tick as packed into in_tdata, highest field first
  typedef struct packed {
    logic signed [PWR_W-1:0]  pwr;
    logic [PV_W-1:0]          pv2;
    logic [PV_W-1:0]          pv1;
    logic signed [TEMP_W-1:0] temp;
    logic                     grid;
  } tick_t;

  // One result as packed into out_tdata, highest field first
  typedef struct packed {
    logic                    derating;
    logic                    stepped;
    logic signed [TGT_W-1:0] target;
    logic [LIM_W-1:0]        limit;
  } limit_res_t;

  typedef enum int {RUN_CALM, RUN_HOT, RUN_OVER, RUN_LOW, RUN_WILD} run_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the register file and of the limiter state
  pdl_cfg_t lim_cfg;
  longint   acc_q21  = 0;
  int       hot_cnt  = 0;
  int       over_cnt = 0;
  int       rec_cnt  = 0;
  bit       ovl_on   = 1'b0;

  limit_res_t pending_limits[$];
  limit_res_t want_res;
  limit_res_t got_res;

  int send_idle_pct = 32;
  int recv_idle_pct = 76;
  bit hold_req      = 1'b0;

  int n_ticks    = 0;
  int n_grid_off = 0;
  int n_checked  = 0;
  int n_writes   = 0;
  int n_therm    = 0;
  int n_stepped  = 0;
  int n_fail     = 0;
  int cycle_cnt  = 0;

  inverter_power_derate_limiter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             pending_limits.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Compute the result of one tick and advance the shadow state
  function automatic limit_res_t predict_limit(input tick_t t);
    limit_res_t r;
    longint     tmp, pv1, pv2, pwr, ovl, rated, tstart, pvs;
    longint     tgt, cand, num, incr, acc, ceil_q16;
    bit         therm;
    r     = '0;
    therm = 1'b0;
    if (!t.grid) begin
      acc_q21  = 0;
      hot_cnt  = 0;
      over_cnt = 0;
      rec_cnt  = 0;
      ovl_on   = 1'b0;
      return r;
    end
    tmp    = $signed(t.temp);
    pv1    = t.pv1;
    pv2    = t.pv2;
    pwr    = $signed(t.pwr);
    ovl    = lim_cfg.ovl_pwr;
    rated  = lim_cfg.rated_pwr;
    tstart = $signed(lim_cfg.temp_start);
    pvs    = lim_cfg.pv_start;
    tgt    = ovl;

    // Thermal derate once the hot run has lasted the delay
    if (tmp > tstart) begin
      if (hot_cnt < int'(lim_cfg.temp_delay)) hot_cnt++;
      if (hot_cnt >= int'(lim_cfg.temp_delay)) begin
        therm = 1'b1;
        cand  = ovl - THERM_SLOPE * (tmp - tstart);
        if (cand < tgt) tgt = cand;
      end
    end else begin
      hot_cnt = 0;
    end

    // PV over-voltage derate per string
    if (pv1 > pvs) begin
      cand = ovl - PV_SLOPE * (pv1 - pvs);
      if (cand < tgt) tgt = cand;
    end
    if (pv2 > pvs) begin
      cand = ovl - PV_SLOPE * (pv2 - pvs);
      if (cand < tgt) tgt = cand;
    end

    // Overload step-down and recovery with saturating tick counters
    if (pwr > rated) begin
      rec_cnt = 0;
      if (!ovl_on) begin
        if (over_cnt < int'(lim_cfg.ovl_ticks)) over_cnt++;
        if (over_cnt >= int'(lim_cfg.ovl_ticks)) ovl_on = 1'b1;
      end
    end else begin
      over_cnt = 0;
      if (ovl_on) begin
        if (rec_cnt < int'(lim_cfg.rec_ticks)) rec_cnt++;
        if (rec_cnt >= int'(lim_cfg.rec_ticks)) ovl_on = 1'b0;
      end
    end
    if (ovl_on && rated < tgt) tgt = rated;
    if (tgt < TGT_MIN) tgt = TGT_MIN;
    if (tgt > TGT_MAX) tgt = TGT_MAX;

    // Integrate the power error, rounded half up, into the clamped accumulator
    num = (tgt - pwr) * Q21_ONE + STEP_HALF;
    if (num >= 0) incr = num / STEP_DIV;
    else          incr = -((-num + STEP_DIV - 1) / STEP_DIV);
    ceil_q16 = lim_cfg.max_cl;
    if (ceil_q16 > Q16_ONE) ceil_q16 = Q16_ONE;
    acc = acc_q21 + incr;
    if (acc > ceil_q16 * ACC_SCALE) acc = ceil_q16 * ACC_SCALE;
    if (acc < 0) acc = 0;
    acc_q21 = acc;

    r.limit    = acc[ACC_W-1:5];
    r.target   = tgt[TGT_W-1:0];
    r.stepped  = ovl_on;
    r.derating = therm;
    return r;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    if (hi <= lo) return hi;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic tick_t mk_tick(input bit grid, input int temp, input int pv1,
                                    input int pv2, input int pwr);
    tick_t t;
    t.grid = grid;
    t.temp = TEMP_W'(temp);
    t.pv1  = PV_W'(pv1);
    t.pv2  = PV_W'(pv2);
    t.pwr  = PWR_W'(pwr);
    return t;
  endfunction

  // Random tick shaped by the run kind around the current thresholds
  function automatic tick_t make_tick(input run_kind_t kind);
    tick_t t;
    int    ts, pvs, rated;
    ts     = $signed(lim_cfg.temp_start);
    pvs    = lim_cfg.pv_start;
    rated  = lim_cfg.rated_pwr;
    t.grid = ($urandom_range(99) >= 2);
    case (kind)
      RUN_HOT:  t.temp = TEMP_W'(rand_between(ts + 1, 2000));
      RUN_WILD: t.temp = TEMP_W'(rand_between(-500, 2000));
      default:  t.temp = TEMP_W'(rand_between(-500, ts));
    endcase
    t.pv1 = PV_W'(($urandom_range(3) == 0) ? rand_between(pvs, 10000)
                                           : rand_between(0, pvs));
    t.pv2 = PV_W'(($urandom_range(3) == 0) ? rand_between(pvs, 10000)
                                           : rand_between(0, pvs));
    case (kind)
      RUN_OVER: t.pwr = PWR_W'(rand_between(rated + 1, 65535));
      RUN_LOW:  t.pwr = PWR_W'(rand_between(-65536, -30000));
      RUN_WILD: t.pwr = PWR_W'(rand_between(-65536, 65535));
      default:  t.pwr = PWR_W'(($urandom_range(1) == 0) ? rand_between(rated - 4000, rated)
                                                        : rand_between(-65536, rated));
    endcase
    return t;
  endfunction

  function automatic pdl_cfg_t random_settings();
    pdl_cfg_t c;
    int       ovl;
    ovl          = rand_between(8000, 65535);
    c.max_cl     = LIM_W'(($urandom_range(3) == 0) ? int'($urandom_range(131071))
                                                   : rand_between(16384, 65536));
    c.ovl_pwr    = POW_W'(ovl);
    c.rated_pwr  = POW_W'(rand_between(ovl / 2, ovl));
    c.temp_start = TEMP_W'(rand_between(-500, 2000));
    c.pv_start   = PV_W'(rand_between(0, 10000));
    c.temp_delay = TICK_W'(($urandom_range(7) == 0) ? $urandom_range(1023)
                                                    : $urandom_range(24));
    c.ovl_ticks  = TICK_W'(($urandom_range(7) == 0) ? $urandom_range(1023)
                                                    : $urandom_range(24));
    c.rec_ticks  = RTICK_W'(($urandom_range(7) == 0) ? $urandom_range(4095)
                                                     : $urandom_range(30));
    return c;
  endfunction

  // Offer one tick, hold it until the transfer, then queue its result
  task automatic send_tick(input tick_t t);
    limit_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - $bits(tick_t)){1'b0}}, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_limit(t);
    pending_limits.push_back(r);
    n_ticks++;
    if (!t.grid)   n_grid_off++;
    if (r.derating) n_therm++;
    if (r.stepped)  n_stepped++;
  endtask

  task automatic cfg_write(input pdl_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAX_CL:     lim_cfg.max_cl     = val;
      CFG_OVL_PWR:    lim_cfg.ovl_pwr    = val[15:0];
      CFG_RATED_PWR:  lim_cfg.rated_pwr  = val[15:0];
      CFG_TEMP_START: lim_cfg.temp_start = val[11:0];
      CFG_PV_START:   lim_cfg.pv_start   = val[13:0];
      CFG_TEMP_DELAY: lim_cfg.temp_delay = val[9:0];
      CFG_OVL_TICKS:  lim_cfg.ovl_ticks  = val[9:0];
      CFG_REC_TICKS:  lim_cfg.rec_ticks  = val[11:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input pdl_cfg_t c);
    cfg_write(CFG_MAX_CL,     c.max_cl);
    cfg_write(CFG_OVL_PWR,    CFG_DATA_W'(c.ovl_pwr));
    cfg_write(CFG_RATED_PWR,  CFG_DATA_W'(c.rated_pwr));
    cfg_write(CFG_TEMP_START, CFG_DATA_W'(c.temp_start));
    cfg_write(CFG_PV_START,   CFG_DATA_W'(c.pv_start));
    cfg_write(CFG_TEMP_DELAY, CFG_DATA_W'(c.temp_delay));
    cfg_write(CFG_OVL_TICKS,  CFG_DATA_W'(c.ovl_ticks));
    cfg_write(CFG_REC_TICKS,  CFG_DATA_W'(c.rec_ticks));
  endtask

  // Drop valid, wait for every queued result, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_limits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Register reset values, field extremes, grid dropout
  task automatic test_reset_values();
    send_tick(mk_tick(0, 2000, 10000, 10000, 65535));
    send_tick(mk_tick(1, -500, 0, 0, -65536));
    send_tick(mk_tick(1, 2000, 10000, 10000, 65535));
    send_tick(mk_tick(1, 651, 5001, 5001, 30001));
    send_tick(mk_tick(1, 650, 5000, 5000, 30000));
  endtask

  // Register extremes: zero delays, extreme power caps, ceiling above full scale
  task automatic test_extreme_settings();
    pdl_cfg_t c;
    wait_drained();
    c.max_cl     = 17'h1FFFF;
    c.ovl_pwr    = 16'hFFFF;
    c.rated_pwr  = 16'd0;
    c.temp_start = -12'sd500;
    c.pv_start   = 14'd0;
    c.temp_delay = 10'd0;
    c.ovl_ticks  = 10'd0;
    c.rec_ticks  = 12'd0;
    load_settings(c);
    send_tick(mk_tick(1, 2000, 10000, 10000, -65536));
    send_tick(mk_tick(1, 2000, 0, 0, 65535));
    send_tick(mk_tick(1, -500, 0, 0, -65536));
    send_tick(mk_tick(1, -499, 1, 1, 0));
    wait_drained();
    c.max_cl     = 17'd0;
    c.ovl_pwr    = 16'd0;
    c.rated_pwr  = 16'hFFFF;
    c.temp_start = 12'sd2000;
    c.pv_start   = 14'd10000;
    c.temp_delay = 10'd1023;
    c.ovl_ticks  = 10'd1023;
    c.rec_ticks  = 12'd4095;
    load_settings(c);
    send_tick(mk_tick(1, 2000, 10000, 10000, 65535));
    send_tick(mk_tick(1, -500, 0, 0, -65536));
  endtask

  // Short thresholds: delay expiry, counter saturation, step-down and recovery
  task automatic test_timer_thresholds();
    pdl_cfg_t c;
    wait_drained();
    c.max_cl     = RST_MAX_CL;
    c.ovl_pwr    = RST_OVL_PWR;
    c.rated_pwr  = RST_RATED_PWR;
    c.temp_start = RST_TEMP_START;
    c.pv_start   = RST_PV_START;
    c.temp_delay = 10'd2;
    c.ovl_ticks  = 10'd3;
    c.rec_ticks  = 12'd2;
    load_settings(c);
    repeat (3) send_tick(mk_tick(1, 700, 4000, 4000, 20000));
    send_tick(mk_tick(1, 600, 4000, 6000, 20000));
    repeat (4) send_tick(mk_tick(1, 600, 4000, 4000, 31000));
    repeat (3) send_tick(mk_tick(1, 600, 4000, 4000, 29000));
    send_tick(mk_tick(0, 700, 4000, 4000, 31000));
  endtask

  // Runs of shaped ticks over three random settings
  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input bit pressure);
    run_kind_t kind;
    int        left;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    kind = RUN_CALM;
    for (int seg = 0; seg < 3; seg++) begin
      wait_drained();
      load_settings(random_settings());
      left = 0;
      for (int i = 0; i < SEG_TICKS; i++) begin
        if (left == 0) begin
          kind = run_kind_t'($urandom_range(4));
          left = rand_between(4, 40);
        end
        left--;
        // Stall the sink for a long stretch while ticks keep coming
        if (pressure && seg == 1 && i == 10) hold_req = 1'b1;
        // Pause the source until every result is back
        if (pressure && seg == 1 && i == 50) wait_drained();
        send_tick(make_tick(kind));
      end
    end
  endtask

  task automatic test_random_slow_sink();
    run_random_phase(32, 76, 1'b0);
  endtask

  task automatic test_random_slow_source();
    run_random_phase(76, 32, 1'b0);
  endtask

  task automatic test_random_full_rate();
    run_random_phase(0, 0, 1'b1);
  endtask

  // Result sink: random backpressure plus a counted hold-off on request
  initial begin : sink
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = HOLD_LEN - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result transfer with the oldest queued result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = out_tdata[$bits(limit_res_t)-1:0];
      if (pending_limits.size() == 0) begin
        $error("result with no tick waiting: current_limit %0d", got_res.limit);
        n_fail++;
      end else begin
        want_res = pending_limits.pop_front();
        n_checked++;
        if (got_res.limit !== want_res.limit) begin
          $error("current_limit: expected %0d, got %0d", want_res.limit, got_res.limit);
          n_fail++;
        end
        if (got_res.target !== want_res.target) begin
          $error("target_power: expected %0d, got %0d", $signed(want_res.target),
                 $signed(got_res.target));
          n_fail++;
        end
        if (got_res.stepped !== want_res.stepped) begin
          $error("overload_stepped: expected %0d, got %0d", want_res.stepped,
                 got_res.stepped);
          n_fail++;
        end
        if (got_res.derating !== want_res.derating) begin
          $error("thermal_derating: expected %0d, got %0d", want_res.derating,
                 got_res.derating);
          n_fail++;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    lim_cfg.max_cl     = RST_MAX_CL;
    lim_cfg.ovl_pwr    = RST_OVL_PWR;
    lim_cfg.rated_pwr  = RST_RATED_PWR;
    lim_cfg.temp_start = RST_TEMP_START;
    lim_cfg.pv_start   = RST_PV_START;
    lim_cfg.temp_delay = RST_TEMP_DELAY;
    lim_cfg.ovl_ticks  = RST_OVL_TICKS;
    lim_cfg.rec_ticks  = RST_REC_TICKS;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_extreme_settings();
    test_timer_thresholds();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();
    wait_drained();

    $display("Covered %0d ticks (%0d with grid dropped), %0d results checked, %0d reg writes",
             n_ticks, n_grid_off, n_checked, n_writes);
    $display("Thermal derate active on %0d results, overload step-down on %0d, %0d mismatches",
             n_therm, n_stepped, n_fail);
    if (n_fail == 0) $display("SUCCESS");
    else             $display("FAILURE");
    $finish;
  end

endmodule
